/* design/lpd_pkg.sv */
// Shared types and constants of the length-prefix deframer.
package lpd_pkg;

  // Field widths and the header length in bytes.
  localparam int unsigned ChannelW  = 4;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned KindW     = 2;
  localparam int unsigned BodyLenW  = 13;
  localparam int unsigned LenAccW   = 32;
  localparam int unsigned HdrCntW   = 2;
  localparam int unsigned HdrBytes  = 4;

  // Number of channels that the channel field can name.
  localparam int unsigned ChannelSpan = 1 << ChannelW;

  // Default number of channels with state.
  localparam int unsigned ChannelsDef = 16;

  // Depths of the two queues.
  localparam int unsigned OpQDepth  = 2;
  localparam int unsigned ResQDepth = 2;

  // Configuration port.
  localparam int unsigned PAddrW = 3;
  localparam int unsigned PDataW = 32;
  localparam logic [BodyLenW-1:0] MaxBodyLenRst = BodyLenW'(4096);

  // Register indexes.
  typedef enum logic [PAddrW-3:0] {
    REG_MAX_BODY_LEN = 1'b0
  } reg_idx_e;

  // Input commands.
  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  // Result kinds.
  typedef enum logic [KindW-1:0] {
    KIND_BODY     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_OVERSIZE = 2'd2
  } kind_e;

  // One operation passed from the front to the back.
  typedef struct packed {
    cmd_e                cmd;
    logic [ChannelW-1:0] channel;
    logic [ByteW-1:0]    data;
  } op_t;

  // One result item.
  typedef struct packed {
    logic [ChannelW-1:0] channel;
    kind_e               kind;
    logic [ByteW-1:0]    data;
    logic                last;
  } res_t;

endpackage

/* design/lpd_fifo.sv */
// Small register queue with a registered head, used for both queues.
module lpd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/lpd_front.sv */
// Front part: accepts input beats, drops absent channels and queues operations.
module lpd_front #(
  parameter int unsigned CHANNELS = lpd_pkg::ChannelsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         command_i,
  input  logic [lpd_pkg::ChannelW-1:0] channel_i,
  input  logic [lpd_pkg::ByteW-1:0]    data_byte_i,
  output lpd_pkg::op_t                 op_o,
  output logic                         op_valid_o,
  input  logic                         op_pop_i
);
  import lpd_pkg::*;

  localparam int unsigned CmpW = $clog2(ChannelSpan + 1) + 11;

  op_t  op_in;
  op_t  op_head;
  logic present;
  logic op_empty;

  // A channel index at or above the channel count has no state and is dropped.
  assign present = (CmpW'(channel_i) < CmpW'(CHANNELS));

  assign op_in.cmd     = cmd_e'(command_i);
  assign op_in.channel = channel_i;
  assign op_in.data    = data_byte_i;

  lpd_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (OpQDepth)
  ) u_op_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && present),
    .data_i  (op_in),
    .full_o  (full),
    .pop_i   (op_pop_i),
    .data_o  (op_head),
    .empty_o (op_empty)
  );

  assign op_o       = op_head;
  assign op_valid_o = !op_empty;

endmodule

/* design/lpd_back.sv */
// Back part: per-channel header and body tracking, and the result queue.
module lpd_back #(
  parameter int unsigned CHANNELS = lpd_pkg::ChannelsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lpd_pkg::op_t                 op_i,
  input  logic                         op_valid_i,
  output logic                         op_pop_o,
  input  logic [lpd_pkg::BodyLenW-1:0] max_body_len_i,
  output lpd_pkg::res_t                res_o,
  output logic                         empty,
  input  logic                         pop
);
  import lpd_pkg::*;

  // Only channels that the channel field can name get state.
  localparam int unsigned Depth = (CHANNELS < ChannelSpan) ? CHANNELS : ChannelSpan;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [HdrCntW-1:0]  hdr_cnt_q   [Depth];
  logic [LenAccW-1:0]  len_acc_q   [Depth];
  logic [BodyLenW-1:0] body_left_q [Depth];
  logic                blocked_q   [Depth];

  logic [IdxW-1:0]     idx;
  logic [HdrCntW-1:0]  hdr_cnt_cur, hdr_cnt_d;
  logic [LenAccW-1:0]  len_acc_cur, len_acc_d, len_new;
  logic [BodyLenW-1:0] body_left_cur, body_left_d;
  logic                blocked_cur, blocked_d;
  logic                fire;
  logic                res_valid;
  logic                res_full;
  res_t                res_d;

  assign idx           = op_i.channel[IdxW-1:0];
  assign hdr_cnt_cur   = hdr_cnt_q[idx];
  assign len_acc_cur   = len_acc_q[idx];
  assign body_left_cur = body_left_q[idx];
  assign blocked_cur   = blocked_q[idx];
  assign len_new       = {len_acc_cur[LenAccW-ByteW-1:0], op_i.data};

  // An operation executes when the result queue has room for its result.
  assign fire     = op_valid_i && !res_full;
  assign op_pop_o = fire;

  // Next state of the addressed channel and the result it gives.
  always_comb begin
    hdr_cnt_d     = hdr_cnt_cur;
    len_acc_d     = len_acc_cur;
    body_left_d   = body_left_cur;
    blocked_d     = blocked_cur;
    res_valid     = 1'b0;
    res_d.channel = op_i.channel;
    res_d.kind    = KIND_BODY;
    res_d.data    = '0;
    res_d.last    = 1'b0;
    if (op_i.cmd == CMD_CLEAR) begin
      hdr_cnt_d   = '0;
      len_acc_d   = '0;
      body_left_d = '0;
      blocked_d   = 1'b0;
    end else if (blocked_cur) begin
      // A blocked channel drops its bytes.
    end else if (body_left_cur != '0) begin
      body_left_d = body_left_cur - 1'b1;
      res_valid   = 1'b1;
      res_d.data  = op_i.data;
      res_d.last  = (body_left_cur == BodyLenW'(1));
    end else if (hdr_cnt_cur != HdrCntW'(HdrBytes - 1)) begin
      hdr_cnt_d = hdr_cnt_cur + 1'b1;
      len_acc_d = len_new;
    end else begin
      // The header is complete: check the length.
      hdr_cnt_d = '0;
      len_acc_d = '0;
      res_valid = 1'b1;
      if (len_new > LenAccW'(max_body_len_i)) begin
        blocked_d  = 1'b1;
        res_d.kind = KIND_OVERSIZE;
      end else if (len_new == '0) begin
        res_d.kind = KIND_EMPTY;
        res_d.last = 1'b1;
      end else begin
        res_valid   = 1'b0;
        body_left_d = len_new[BodyLenW-1:0];
      end
    end
  end

  // Per-channel state table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        hdr_cnt_q[i]   <= '0;
        len_acc_q[i]   <= '0;
        body_left_q[i] <= '0;
        blocked_q[i]   <= 1'b0;
      end
    end else if (fire) begin
      hdr_cnt_q[idx]   <= hdr_cnt_d;
      len_acc_q[idx]   <= len_acc_d;
      body_left_q[idx] <= body_left_d;
      blocked_q[idx]   <= blocked_d;
    end
  end

  // Results wait here for the receiver.
  lpd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (ResQDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire && res_valid),
    .data_i  (res_d),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_o),
    .empty_o (empty)
  );

endmodule

/* design/multichannel_length_prefix_deframer.sv */
// Top level of the multichannel length-prefix deframer.
//
// Input beats arrive through a queue-style port (push/full): each beat is a
// received byte or a clear command for one channel. Every channel carries
// messages that open with a 4-byte big-endian body length. Header bytes give
// no result; a zero length gives an empty-message marker; body bytes are
// passed out with last set on the final one; an oversize length gives one
// error result and blocks the channel until it is cleared.
// Results leave through a queue-style port (empty/pop).
// An accepted beat is registered in the operation queue; the back part then
// executes it and registers any result in the result queue. One beat is
// taken every cycle while full is low; the back part reads and writes channel
// state in the same cycle, so back-to-back beats on one channel need no stall.
// If the receiver stops popping, the result queue fills, the back part stops
// and the operation queue then raises full.
// Reset clears all channel state and both queues and sets max_body_len to
// 4096. The register sits at byte address 0 of the APB port.
module multichannel_length_prefix_deframer #(
  parameter int unsigned CHANNELS = lpd_pkg::ChannelsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input queue port.
  input  logic                         push,
  output logic                         full,
  input  logic                         command_i,
  input  logic [lpd_pkg::ChannelW-1:0] channel_i,
  input  logic [lpd_pkg::ByteW-1:0]    data_byte_i,
  // Result queue port.
  output logic                         empty,
  input  logic                         pop,
  output logic [lpd_pkg::ChannelW-1:0] out_channel_o,
  output logic [lpd_pkg::KindW-1:0]    kind_o,
  output logic [lpd_pkg::ByteW-1:0]    out_byte_o,
  output logic                         last_o,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpd_pkg::PAddrW-1:0]   paddr,
  input  logic [lpd_pkg::PDataW-1:0]   pwdata,
  output logic [lpd_pkg::PDataW-1:0]   prdata,
  output logic                         pready
);
  import lpd_pkg::*;

  logic [BodyLenW-1:0] max_body_len_q;
  logic                cfg_wr;
  reg_idx_e            reg_idx;
  op_t                 op;
  logic                op_valid;
  logic                op_pop;
  res_t                res;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PAddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_len_q <= MaxBodyLenRst;
    end else if (cfg_wr && (reg_idx == REG_MAX_BODY_LEN)) begin
      max_body_len_q <= pwdata[BodyLenW-1:0];
    end
  end

  assign prdata = (reg_idx == REG_MAX_BODY_LEN) ? PDataW'(max_body_len_q) : '0;

  lpd_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .command_i   (command_i),
    .channel_i   (channel_i),
    .data_byte_i (data_byte_i),
    .op_o        (op),
    .op_valid_o  (op_valid),
    .op_pop_i    (op_pop)
  );

  lpd_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .op_valid_i     (op_valid),
    .op_pop_o       (op_pop),
    .max_body_len_i (max_body_len_q),
    .res_o          (res),
    .empty          (empty),
    .pop            (pop)
  );

  assign out_channel_o = res.channel;
  assign kind_o        = res.kind;
  assign out_byte_o    = res.data;
  assign last_o        = res.last;

  // An error result carries no byte and does not end a message.
  a_oversize_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (kind_o == KIND_OVERSIZE)) |-> (!last_o && (out_byte_o == '0)))
    else $error("oversize result with byte or last set");

  // An empty-message marker always ends a message and carries no byte.
  a_empty_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (kind_o == KIND_EMPTY)) |-> (last_o && (out_byte_o == '0)))
    else $error("empty-message marker malformed");

  // Only defined result kinds reach the output.
  a_kind_defined : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((kind_o == KIND_BODY) || (kind_o == KIND_EMPTY) ||
                (kind_o == KIND_OVERSIZE)))
    else $error("undefined result kind");

  // The back part never executes an operation that is not there.
  a_op_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop |-> op_valid)
    else $error("operation popped from empty queue");

endmodule
